// ----- sv/litu_pkg.sv -----
package litu_pkg;

    localparam int TIME_W = 64;
    localparam int CMD_W = 3;
    localparam int CFG_W = 32;
    localparam int CFG_IDX_W = 8;
    localparam int DIV_STEPS = TIME_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CMD_W-1:0] CMD_UPDATE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_RESET = 3'd1;
    localparam logic [CMD_W-1:0] CMD_RESET_PERIOD = 3'd2;
    localparam logic [CMD_W-1:0] CMD_EVERY = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_INTERVAL = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_LENGTH = 8'd3;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic apply;
        logic div_init;
        logic div_step;
        logic div_finish;
        logic report;
    } litu_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             started;
        logic             period_nz;
        logic             el_ge_period;
        logic             out_free;
    } litu_sts_t;

endpackage

// ----- sv/litu_req_if.sv -----
interface litu_req_if
    import litu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now_us;

    modport source (output valid, output cmd, output now_us, input ready);
    modport sink (input valid, input cmd, input now_us, output ready);
endinterface

// ----- sv/litu_rsp_if.sv -----
interface litu_rsp_if
    import litu_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] interval_us;
    logic              fired;
    logic              expired;
    logic [TIME_W-1:0] since_start_us;
    logic [TIME_W-1:0] since_update_us;
    logic              running;

    modport source (output valid, output interval_us, output fired, output expired,
                    output since_start_us, output since_update_us, output running,
                    input ready);
    modport sink (input valid, input interval_us, input fired, input expired,
                  input since_start_us, input since_update_us, input running,
                  output ready);
endinterface

// ----- sv/litu_cfg_if.sv -----
interface litu_cfg_if
    import litu_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/litu_ctrl.sv -----
module litu_ctrl
    import litu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  litu_sts_t sts,
    output litu_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_DIV = 3'd2;
    localparam logic [2:0] ST_FIN = 3'd3;
    localparam logic [2:0] ST_REPORT = 3'd4;

    logic [2:0]           state_reg;
    logic [2:0]           state_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 need_div;

    assign in_ready = (state_reg == ST_IDLE);
    assign need_div = (sts.cmd == CMD_EVERY) && sts.started && sts.period_nz
                      && sts.el_ge_period;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        cmd = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (need_div)
                begin
                    cmd.div_init = 1'b1;
                    cnt_next = '0;
                    state_next = ST_DIV;
                end
                else
                begin
                    cmd.apply = 1'b1;
                    state_next = ST_REPORT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.div_finish = 1'b1;
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (sts.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_runs_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && cnt_reg == '0) |-> $past(state_reg) == ST_EXEC)
        else $error("divider entered without init");
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == ST_EXEC && !in_ready)
        else $error("controller took a request outside idle");
    a_fin_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_FIN |-> $past(state_reg) == ST_DIV
        && $past(cnt_reg) == DIV_CNT_W'(DIV_STEPS - 1))
        else $error("finish without full division");
`endif

endmodule

// ----- sv/litu_dp.sv -----
module litu_dp
    import litu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  litu_cmd_t            cmd,
    output litu_sts_t            sts,
    input  logic [CMD_W-1:0]     in_cmd,
    input  logic [TIME_W-1:0]    in_now_us,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [TIME_W-1:0]    out_interval_us,
    output logic                 out_fired,
    output logic                 out_expired,
    output logic [TIME_W-1:0]    out_since_start_us,
    output logic [TIME_W-1:0]    out_since_update_us,
    output logic                 out_running
);

    // configuration
    logic [CFG_W-1:0] first_interval_reg;
    logic [CFG_W-1:0] min_interval_reg;
    logic [CFG_W-1:0] max_interval_reg;
    logic [CFG_W-1:0] period_length_reg;

    // timer state
    logic [TIME_W-1:0] start_mark_reg;
    logic [TIME_W-1:0] last_update_mark_reg;
    logic [TIME_W-1:0] anchor_mark_reg;
    logic [TIME_W-1:0] last_interval_reg;
    logic              started_reg;
    logic              fired_reg;

    // captured request
    logic [CMD_W-1:0]  cmd_reg;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] el_reg;
    logic [TIME_W-1:0] dt_reg;

    // remainder divider
    logic [TIME_W-1:0] dvd_reg;
    logic [CFG_W-1:0]  rem_reg;
    logic [CFG_W:0]    rem_trial;
    logic [CFG_W:0]    rem_diff;

    logic [TIME_W-1:0] clamp_in;
    logic [TIME_W-1:0] clamp_out;
    logic [TIME_W-1:0] anchor_diff;
    logic              period_nz;

    function automatic logic [TIME_W-1:0] clamp_dt(
        input logic [TIME_W-1:0] dt,
        input logic [CFG_W-1:0]  lo_cfg,
        input logic [CFG_W-1:0]  hi_cfg
    );
        logic [TIME_W-1:0] lo;
        logic [TIME_W-1:0] hi;
        logic [TIME_W-1:0] res;
        lo = TIME_W'(lo_cfg);
        hi = TIME_W'(hi_cfg);
        res = dt;
        if (hi != '0 && lo > hi)
        begin
            lo = hi;
        end
        if (lo != '0 && dt < lo)
        begin
            res = lo;
        end
        if (hi != '0 && res > hi)
        begin
            res = hi;
        end
        return res;
    endfunction

    assign period_nz = (period_length_reg != '0);
    assign clamp_in = started_reg ? dt_reg : TIME_W'(first_interval_reg);
    assign clamp_out = clamp_dt(clamp_in, min_interval_reg, max_interval_reg);
    assign anchor_diff = now_reg - anchor_mark_reg;

    assign rem_trial = {rem_reg, dvd_reg[TIME_W-1]};
    assign rem_diff = rem_trial - {1'b0, period_length_reg};

    always_comb
    begin
        sts.cmd = cmd_reg;
        sts.started = started_reg;
        sts.period_nz = period_nz;
        sts.el_ge_period = (el_reg >= TIME_W'(period_length_reg));
        sts.out_free = !out_valid || out_ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_interval_reg <= '0;
            min_interval_reg <= '0;
            max_interval_reg <= '0;
            period_length_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_FIRST_INTERVAL: first_interval_reg <= cfg_data;
                CFG_MIN_INTERVAL:   min_interval_reg <= cfg_data;
                CFG_MAX_INTERVAL:   max_interval_reg <= cfg_data;
                CFG_PERIOD_LENGTH:  period_length_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cmd_reg <= in_cmd;
            now_reg <= in_now_us;
            el_reg <= in_now_us - anchor_mark_reg;
            dt_reg <= in_now_us - last_update_mark_reg;
        end
        if (cmd.div_init)
        begin
            dvd_reg <= el_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[TIME_W-2:0], 1'b0};
            rem_reg <= rem_diff[CFG_W] ? rem_trial[CFG_W-1:0] : rem_diff[CFG_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_mark_reg <= '0;
            last_update_mark_reg <= '0;
            anchor_mark_reg <= '0;
            last_interval_reg <= '0;
            started_reg <= 1'b0;
            fired_reg <= 1'b0;
        end
        else if (cmd.apply)
        begin
            fired_reg <= 1'b0;
            case (cmd_reg)
                CMD_UPDATE:
                begin
                    last_update_mark_reg <= now_reg;
                    last_interval_reg <= clamp_out;
                    if (!started_reg)
                    begin
                        start_mark_reg <= now_reg;
                        anchor_mark_reg <= now_reg;
                        started_reg <= 1'b1;
                    end
                end
                CMD_RESET:
                begin
                    start_mark_reg <= now_reg;
                    last_update_mark_reg <= now_reg;
                    anchor_mark_reg <= now_reg;
                    last_interval_reg <= '0;
                    started_reg <= 1'b1;
                end
                CMD_RESET_PERIOD:
                begin
                    anchor_mark_reg <= now_reg;
                    if (!started_reg)
                    begin
                        start_mark_reg <= now_reg;
                        last_update_mark_reg <= now_reg;
                        started_reg <= 1'b1;
                    end
                end
                CMD_EVERY:
                begin
                    if (period_nz && !started_reg)
                    begin
                        start_mark_reg <= now_reg;
                        last_update_mark_reg <= now_reg;
                        anchor_mark_reg <= now_reg;
                        last_interval_reg <= '0;
                        started_reg <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.div_finish)
        begin
            // anchor + el - el mod period lands on now minus the remainder
            anchor_mark_reg <= now_reg - TIME_W'(rem_reg);
            fired_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.report)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.report)
        begin
            out_interval_us <= last_interval_reg;
            out_fired <= fired_reg;
            out_expired <= started_reg && period_nz
                           && (anchor_diff >= TIME_W'(period_length_reg));
            out_since_start_us <= started_reg ? (now_reg - start_mark_reg) : '0;
            out_since_update_us <= started_reg ? (now_reg - last_update_mark_reg) : '0;
            out_running <= started_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_rem_below_period: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> rem_reg < period_length_reg)
        else $error("remainder not below period");
    a_fire_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_finish |=> fired_reg && started_reg)
        else $error("fire did not set flag");
    a_report_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |-> (!out_valid || out_ready))
        else $error("result overwritten while held");
    a_fired_not_expired: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report && fired_reg |=> !out_expired)
        else $error("fired result still expired");
`endif

endmodule

// ----- sv/loop_interval_timer_unit.sv -----
// Loop interval timer for control loops, driven by a free-running microsecond
// timestamp carried with every request.
// Channels: req (sink) carries cmd and now_us; rsp (source) returns one result
// per request; cfg (sink) writes first_interval, min_interval, max_interval and
// period_length at index 0 to 3. cfg is always ready; the user must write it
// only while idle, as the block does not enforce this. Each request is
// captured and applied, and its result is then registered once the output
// register is free; an every command that fires instead runs the bit-serial
// remainder unit that realigns the period anchor (one quotient bit per cycle
// over the 64-bit elapsed time) and applies the new anchor. req.ready is high
// only while the controller is idle, so requests are taken one at a time,
// none before the last result is registered.
// Reset clears all configuration, marks, the stored interval and the running
// flag; the timer stays stopped until update, reset, reset_period, or every
// with a nonzero period, starts it. When the receiver stalls, the result waits
// in the output register while the next request is accepted and processed;
// that request's result is held back until the output register is taken.
module loop_interval_timer_unit
    import litu_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    litu_req_if.sink   req,
    litu_rsp_if.source rsp,
    litu_cfg_if.sink   cfg
);

    litu_cmd_t ctrl_cmd;
    litu_sts_t dp_sts;
    logic      in_ready;

    // accept configuration at any time; the user writes only while idle
    assign cfg.ready = 1'b1;
    assign req.ready = in_ready;

    litu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (dp_sts),
        .cmd      (ctrl_cmd)
    );

    litu_dp u_dp (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (ctrl_cmd),
        .sts                 (dp_sts),
        .in_cmd              (req.cmd),
        .in_now_us           (req.now_us),
        .cfg_write           (cfg.valid),
        .cfg_index           (cfg.index),
        .cfg_data            (cfg.data),
        .out_valid           (rsp.valid),
        .out_ready           (rsp.ready),
        .out_interval_us     (rsp.interval_us),
        .out_fired           (rsp.fired),
        .out_expired         (rsp.expired),
        .out_since_start_us  (rsp.since_start_us),
        .out_since_update_us (rsp.since_update_us),
        .out_running         (rsp.running)
    );

endmodule
